// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker module of the curvature unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and masked while i_rst_n is low.
`define CFMV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cfmv check failed");

// Next-cycle implication, sampled on i_clk and masked while i_rst_n is low.
`define CFMV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cfmv check failed");

`endif

// ===== src/cfmv_pkg.sv =====
// ----------------------------------------------------------------------------
// cfmv_pkg
// Types, constants and helpers of the curvature-from-motion-vectors unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cfmv_pkg;

    localparam int DIM     = 3;
    localparam int NCOMP   = (DIM < 3) ? DIM : 3;
    localparam int NPAIR   = (NCOMP * (NCOMP - 1)) / 2;
    localparam int CIDX_W  = (NCOMP > 2) ? 2 : 1;
    localparam int PIDX_W  = (NPAIR > 2) ? 2 : 1;

    localparam int W_FIX   = 32;
    localparam int W_OP    = W_FIX + 1;
    localparam int W_PROD  = 2 * W_OP;
    localparam int W_ACC   = 6 * W_FIX;
    localparam int W_SHIFT = 3;
    localparam int STEP_W  = 6;

    localparam logic [W_FIX-1:0] RESET_MIN_ENERGY = 32'd4295;
    localparam logic [W_FIX-1:0] CURV_MAX         = 32'h7FFF_FFFF;

    // Last step index of each phase; a MAC phase reads the accumulator there.
    localparam logic [STEP_W-1:0] VV_DONE   = STEP_W'(NCOMP + 1);
    localparam logic [STEP_W-1:0] DIFF_DONE = 6'd3;
    localparam logic [STEP_W-1:0] SQ_DONE   = 6'd5;
    localparam logic [STEP_W-1:0] MV_DONE   = 6'd3;
    localparam logic [STEP_W-1:0] V2_DONE   = 6'd5;
    localparam logic [STEP_W-1:0] V3_DONE   = 6'd9;
    localparam logic [STEP_W-1:0] DIV_DONE  = 6'd63;
    localparam logic [STEP_W-1:0] SQRT_DONE = 6'd31;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VV,
        S_DIFF,
        S_SQ,
        S_MV,
        S_V2,
        S_V3,
        S_SAT,
        S_DIV,
        S_SQRT,
        S_OUT
    } t_state;

    typedef enum logic {
        ACC_A,
        ACC_B
    } t_acc_sel;

    typedef struct packed {
        logic                valid;
        logic                clr;
        t_acc_sel            dst;
        logic [W_SHIFT-1:0]  shift;
    } t_mac_ctl;

    // First component index of pair k, pairs ordered (0,1), (0,2), (1,2).
    function automatic logic [CIDX_W-1:0] pair_first(input logic [PIDX_W-1:0] k);
        int n;
        logic [CIDX_W-1:0] r;
        n = 0;
        r = '0;
        for (int i = 0; i < NCOMP; i++) begin
            for (int j = i + 1; j < NCOMP; j++) begin
                if (n == int'(k)) begin
                    r = CIDX_W'(i);
                end
                n++;
            end
        end
        return r;
    endfunction

    // Second component index of pair k.
    function automatic logic [CIDX_W-1:0] pair_second(input logic [PIDX_W-1:0] k);
        int n;
        logic [CIDX_W-1:0] r;
        n = 0;
        r = '0;
        for (int i = 0; i < NCOMP; i++) begin
            for (int j = i + 1; j < NCOMP; j++) begin
                if (n == int'(k)) begin
                    r = CIDX_W'(j);
                end
                n++;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/cfmv_mac.sv =====
// ----------------------------------------------------------------------------
// cfmv_mac
// Shared signed 33x33 multiplier with a registered product and two wide
// accumulators; the product is added at a selectable 32-bit limb offset.
// ----------------------------------------------------------------------------
`default_nettype none

module cfmv_mac (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire cfmv_pkg::t_mac_ctl              i_ctl,
    input  wire logic signed [cfmv_pkg::W_OP-1:0] i_a,
    input  wire logic signed [cfmv_pkg::W_OP-1:0] i_b,
    output logic [cfmv_pkg::W_ACC-1:0]           o_acc_a,
    output logic [cfmv_pkg::W_ACC-1:0]           o_acc_b
);

    cfmv_pkg::t_mac_ctl                   r_ctl;
    logic signed [cfmv_pkg::W_PROD-1:0]   r_prod;
    logic [cfmv_pkg::W_ACC-1:0]           r_acc_a;
    logic [cfmv_pkg::W_ACC-1:0]           r_acc_b;
    logic [cfmv_pkg::W_ACC-1:0]           w_ext;
    logic [cfmv_pkg::W_ACC-1:0]           w_base;
    logic [cfmv_pkg::W_ACC-1:0]           n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= cfmv_pkg::W_PROD'(i_a) * cfmv_pkg::W_PROD'(i_b);
    end

    always_comb begin
        w_ext = {{(cfmv_pkg::W_ACC - cfmv_pkg::W_PROD){r_prod[cfmv_pkg::W_PROD-1]}}, r_prod};
        if (r_ctl.clr) begin
            w_base = '0;
        end else if (r_ctl.dst == cfmv_pkg::ACC_B) begin
            w_base = r_acc_b;
        end else begin
            w_base = r_acc_a;
        end
        n_acc = w_base + (w_ext << {r_ctl.shift, 5'b0});
    end

    always_ff @(posedge i_clk) begin
        if (r_ctl.valid) begin
            if (r_ctl.dst == cfmv_pkg::ACC_B) begin
                r_acc_b <= n_acc;
            end else begin
                r_acc_a <= n_acc;
            end
        end
    end

    assign o_acc_a = r_acc_a;
    assign o_acc_b = r_acc_b;

endmodule

`default_nettype wire

// ===== src/curvature_from_motion_vectors_unit.sv =====
// ----------------------------------------------------------------------------
// curvature_from_motion_vectors_unit
// Path curvature |e2| / |p|^2 from a velocity/acceleration sample and the
// velocity of the previous present sample, in exact integer arithmetic.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// s_axis   | in        | tdata: vel_x, vel_y, vel_z, acc_x, acc_y, acc_z; tuser: present
// m_axis   | out       | tdata: curvature; tuser: degenerate
// cfg      | in        | min_energy, written with i_cfg_wr_en
//
// A present request runs its products on the shared 33x33 multiplier, a saturation
// check, then 64 division and 32 square-root steps; a saturated result skips the
// later steps, a degenerate one ends at the threshold test, an absent one skips all.
// One request is in flight at a time; s_axis_tready is high only when idle, and a
// stalled result holds the unit. Reset (synchronous, active low) clears the stored
// velocity to zero and loads the default threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module curvature_from_motion_vectors_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [191:0] s_axis_tdata,  // vel_x, vel_y, vel_z, acc_x, acc_y, acc_z
    input  wire  [0:0]   s_axis_tuser,  // curve_present
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // curvature
    output logic [0:0]   m_axis_tuser,  // degenerate
    input  wire          i_cfg_wr_en,
    input  wire  [31:0]  i_cfg_wr_data
);

    localparam int NC = cfmv_pkg::NCOMP;
    localparam int FW = cfmv_pkg::W_FIX;

    cfmv_pkg::t_state             r_state;
    cfmv_pkg::t_state             n_state;
    logic [cfmv_pkg::STEP_W-1:0]  r_step;
    logic [cfmv_pkg::STEP_W-1:0]  n_step;
    logic [cfmv_pkg::PIDX_W-1:0]  r_pair;

    logic signed [FW-1:0]         r_prior [NC];
    logic signed [FW-1:0]         r_p     [NC];
    logic signed [FW-1:0]         r_a     [NC];
    logic [FW-1:0]                r_min_energy;

    logic [63:0]                  r_vv;
    logic [63:0]                  r_mag;
    logic [127:0]                 r_cc;
    logic [127:0]                 r_v2;
    logic [191:0]                 r_den;
    logic [191:0]                 r_rem;
    logic [63:0]                  r_q;
    logic [63:0]                  r_x;
    logic [63:0]                  r_res;
    logic [63:0]                  r_bit;
    logic [FW-1:0]                r_curv;
    logic                         r_deg;

    cfmv_pkg::t_mac_ctl           w_ctl;
    logic signed [cfmv_pkg::W_OP-1:0] w_opa;
    logic signed [cfmv_pkg::W_OP-1:0] w_opb;
    logic [cfmv_pkg::W_ACC-1:0]   w_acc_a;
    logic [cfmv_pkg::W_ACC-1:0]   w_acc_b;

    logic [cfmv_pkg::CIDX_W-1:0]  w_ci;
    logic [cfmv_pkg::CIDX_W-1:0]  w_cj;
    logic [cfmv_pkg::CIDX_W-1:0]  w_cs;
    logic [64:0]                  w_diff;
    logic [63:0]                  w_mag;
    logic [95:0]                  w_mv;
    logic                         w_small;
    logic                         w_sat;
    logic [192:0]                 w_trial;
    logic                         w_ge;
    logic [63:0]                  w_qn;
    logic [63:0]                  w_sum;
    logic                         w_take;
    logic [63:0]                  w_resn;
    logic                         w_accept;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    cfmv_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_opa),
        .i_b     (w_opb),
        .o_acc_a (w_acc_a),
        .o_acc_b (w_acc_b)
    );

    // ---------------------------------------------------------------- datapath helpers
    always_comb begin
        w_ci    = cfmv_pkg::pair_first(r_pair);
        w_cj    = cfmv_pkg::pair_second(r_pair);
        w_cs    = r_step[cfmv_pkg::CIDX_W-1:0];
        w_diff  = w_acc_a[64:0];
        w_mag   = w_diff[64] ? 64'(-w_diff) : w_diff[63:0];
        w_mv    = w_acc_a[95:0];
        w_small = (r_vv == '0) || (r_vv < {32'b0, r_min_energy}) || (r_cc == '0)
                  || (r_cc < {32'b0, w_mv});
        w_sat   = {62'b0, r_cc, 2'b0} >= r_den;
        w_trial = {r_rem, 1'b0};
        w_ge    = w_trial >= {1'b0, r_den};
        w_qn    = {r_q[62:0], w_ge};
        w_sum   = r_res + r_bit;
        w_take  = r_x >= w_sum;
        w_resn  = w_take ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfmv_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_step        = r_step + 1'b1;
        w_ctl         = '0;
        w_opa         = '0;
        w_opb         = '0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (r_state)
            cfmv_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                n_step        = '0;
                if (s_axis_tvalid) begin
                    n_state = s_axis_tuser[0] ? cfmv_pkg::S_VV : cfmv_pkg::S_OUT;
                end
            end
            cfmv_pkg::S_VV: begin
                if (r_step < cfmv_pkg::STEP_W'(NC)) begin
                    w_ctl.valid = 1'b1;
                    w_ctl.clr   = (r_step == '0);
                    w_ctl.dst   = cfmv_pkg::ACC_A;
                    w_opa       = {r_p[w_cs][FW-1], r_p[w_cs]};
                    w_opb       = {r_p[w_cs][FW-1], r_p[w_cs]};
                end
                if (r_step == cfmv_pkg::VV_DONE) begin
                    n_state = cfmv_pkg::S_DIFF;
                    n_step  = '0;
                end
            end
            cfmv_pkg::S_DIFF: begin
                // a_i * p_j - a_j * p_i, the second product taken with -p_i.
                if (r_step == 6'd0) begin
                    w_ctl.valid = 1'b1;
                    w_ctl.clr   = 1'b1;
                    w_ctl.dst   = cfmv_pkg::ACC_A;
                    w_opa       = {r_a[w_ci][FW-1], r_a[w_ci]};
                    w_opb       = {r_p[w_cj][FW-1], r_p[w_cj]};
                end else if (r_step == 6'd1) begin
                    w_ctl.valid = 1'b1;
                    w_ctl.dst   = cfmv_pkg::ACC_A;
                    w_opa       = {r_a[w_cj][FW-1], r_a[w_cj]};
                    w_opb       = -{r_p[w_ci][FW-1], r_p[w_ci]};
                end
                if (r_step == cfmv_pkg::DIFF_DONE) begin
                    n_state = cfmv_pkg::S_SQ;
                    n_step  = '0;
                end
            end
            cfmv_pkg::S_SQ: begin
                w_ctl.dst = cfmv_pkg::ACC_B;
                if (r_step < 6'd4) begin
                    w_ctl.valid = 1'b1;
                    w_ctl.clr   = (r_step == '0) && (r_pair == '0);
                    w_ctl.shift = {1'b0, r_step[1:0] == 2'd3, r_step[1:0] == 2'd1
                                   || r_step[1:0] == 2'd2};
                    w_opa       = {1'b0, r_step[1] ? r_mag[63:32] : r_mag[31:0]};
                    w_opb       = {1'b0, (r_step[1:0] == 2'd1 || r_step[1:0] == 2'd3)
                                   ? r_mag[63:32] : r_mag[31:0]};
                end
                if (r_step == cfmv_pkg::SQ_DONE) begin
                    n_step  = '0;
                    n_state = (r_pair == cfmv_pkg::PIDX_W'(cfmv_pkg::NPAIR - 1))
                              ? cfmv_pkg::S_MV : cfmv_pkg::S_DIFF;
                end
            end
            cfmv_pkg::S_MV: begin
                if (r_step < 6'd2) begin
                    w_ctl.valid = 1'b1;
                    w_ctl.clr   = (r_step == '0);
                    w_ctl.dst   = cfmv_pkg::ACC_A;
                    w_ctl.shift = {2'b0, r_step[0]};
                    w_opa       = {1'b0, r_min_energy};
                    w_opb       = {1'b0, r_step[0] ? r_vv[63:32] : r_vv[31:0]};
                end
                if (r_step == cfmv_pkg::MV_DONE) begin
                    n_step  = '0;
                    n_state = w_small ? cfmv_pkg::S_OUT : cfmv_pkg::S_V2;
                end
            end
            cfmv_pkg::S_V2: begin
                if (r_step < 6'd4) begin
                    w_ctl.valid = 1'b1;
                    w_ctl.clr   = (r_step == '0);
                    w_ctl.dst   = cfmv_pkg::ACC_A;
                    w_ctl.shift = {1'b0, r_step[1:0] == 2'd3, r_step[1:0] == 2'd1
                                   || r_step[1:0] == 2'd2};
                    w_opa       = {1'b0, r_step[1] ? r_vv[63:32] : r_vv[31:0]};
                    w_opb       = {1'b0, (r_step[1:0] == 2'd1 || r_step[1:0] == 2'd3)
                                   ? r_vv[63:32] : r_vv[31:0]};
                end
                if (r_step == cfmv_pkg::V2_DONE) begin
                    n_state = cfmv_pkg::S_V3;
                    n_step  = '0;
                end
            end
            cfmv_pkg::S_V3: begin
                // Limb i of vv^2 times limb j of vv lands at limb i + j.
                if (r_step < 6'd8) begin
                    w_ctl.valid = 1'b1;
                    w_ctl.clr   = (r_step == '0);
                    w_ctl.dst   = cfmv_pkg::ACC_A;
                    w_ctl.shift = {1'b0, r_step[2:1]} + {2'b0, r_step[0]};
                    w_opa       = {1'b0, r_v2[{r_step[2:1], 5'b0} +: 32]};
                    w_opb       = {1'b0, r_step[0] ? r_vv[63:32] : r_vv[31:0]};
                end
                if (r_step == cfmv_pkg::V3_DONE) begin
                    n_state = cfmv_pkg::S_SAT;
                    n_step  = '0;
                end
            end
            cfmv_pkg::S_SAT: begin
                n_step  = '0;
                n_state = w_sat ? cfmv_pkg::S_OUT : cfmv_pkg::S_DIV;
            end
            cfmv_pkg::S_DIV: begin
                if (r_step == cfmv_pkg::DIV_DONE) begin
                    n_state = cfmv_pkg::S_SQRT;
                    n_step  = '0;
                end
            end
            cfmv_pkg::S_SQRT: begin
                if (r_step == cfmv_pkg::SQRT_DONE) begin
                    n_state = cfmv_pkg::S_OUT;
                    n_step  = '0;
                end
            end
            cfmv_pkg::S_OUT: begin
                m_axis_tvalid = 1'b1;
                n_step        = '0;
                if (m_axis_tready) begin
                    n_state = cfmv_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cfmv_pkg::S_IDLE;
                n_step  = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------- state with reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_energy <= cfmv_pkg::RESET_MIN_ENERGY;
            for (int i = 0; i < NC; i++) begin
                r_prior[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_min_energy <= i_cfg_wr_data;
            end
            if (w_accept && s_axis_tuser[0]) begin
                for (int i = 0; i < NC; i++) begin
                    r_prior[i] <= s_axis_tdata[i*FW +: FW];
                end
            end
        end
    end

    // ---------------------------------------------------------------- working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cfmv_pkg::S_IDLE: begin
                r_pair <= '0;
                r_curv <= '0;
                r_deg  <= 1'b1;
                for (int i = 0; i < NC; i++) begin
                    r_p[i] <= r_prior[i];
                    r_a[i] <= s_axis_tdata[(3 + i)*FW +: FW];
                end
            end
            cfmv_pkg::S_VV: begin
                if (r_step == cfmv_pkg::VV_DONE) begin
                    r_vv <= w_acc_a[63:0];
                end
            end
            cfmv_pkg::S_DIFF: begin
                if (r_step == cfmv_pkg::DIFF_DONE) begin
                    r_mag <= w_mag;
                end
            end
            cfmv_pkg::S_SQ: begin
                if (r_step == cfmv_pkg::SQ_DONE) begin
                    r_pair <= r_pair + 1'b1;
                    r_cc   <= w_acc_b[127:0];
                end
            end
            cfmv_pkg::S_MV: begin
                // The degenerate result is already loaded; nothing to do here.
            end
            cfmv_pkg::S_V2: begin
                if (r_step == cfmv_pkg::V2_DONE) begin
                    r_v2 <= w_acc_a[127:0];
                end
            end
            cfmv_pkg::S_V3: begin
                if (r_step == cfmv_pkg::V3_DONE) begin
                    r_den <= w_acc_a;
                end
            end
            cfmv_pkg::S_SAT: begin
                r_rem <= {64'b0, r_cc};
                r_q   <= '0;
                if (w_sat) begin
                    r_curv <= cfmv_pkg::CURV_MAX;
                    r_deg  <= 1'b0;
                end
            end
            cfmv_pkg::S_DIV: begin
                r_rem <= w_ge ? 192'(w_trial - {1'b0, r_den}) : w_trial[191:0];
                r_q   <= w_qn;
                if (r_step == cfmv_pkg::DIV_DONE) begin
                    r_x   <= w_qn;
                    r_res <= '0;
                    r_bit <= 64'h4000_0000_0000_0000;
                end
            end
            cfmv_pkg::S_SQRT: begin
                if (w_take) begin
                    r_x <= r_x - w_sum;
                end
                r_res <= w_resn;
                r_bit <= r_bit >> 2;
                if (r_step == cfmv_pkg::SQRT_DONE) begin
                    r_curv <= w_resn[FW-1:0];
                    r_deg  <= 1'b0;
                end
            end
            cfmv_pkg::S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tdata = r_curv;
    assign m_axis_tuser = r_deg;

endmodule

`default_nettype wire

// ===== src/cfmv_chk.sv =====
// ----------------------------------------------------------------------------
// cfmv_chk
// Port-level checks on the curvature unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cfmv_chk (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tvalid,
    input wire         s_axis_tready,
    input wire [191:0] s_axis_tdata,
    input wire [0:0]   s_axis_tuser,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [31:0]  m_axis_tdata,
    input wire [0:0]   m_axis_tuser,
    input wire         i_cfg_wr_en,
    input wire [31:0]  i_cfg_wr_data
);

    // A result waiting for its taker stays offered.
    `CFMV_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // A forced zero really is zero.
    `CFMV_ASSERT_IMP(a_deg_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 32'd0)

    // Curvature is a magnitude and is never negative.
    `CFMV_ASSERT_IMP(a_non_neg, m_axis_tvalid, !m_axis_tdata[31])

    // One request at a time: after an accepted request the input side is closed.
    `CFMV_ASSERT_NXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind curvature_from_motion_vectors_unit cfmv_chk u_cfmv_chk (.*);

`default_nettype wire
